/* design/ps2kd_pkg.sv */
// Package with the shared types, codes and lookup tables of the PS/2 key decoder.
package ps2kd_pkg;

  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned KEY_WORD_W = 13;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

  localparam logic [7:0] CODE_BREAK = 8'hF0;
  localparam logic [7:0] CODE_EXT = 8'hE0;
  localparam logic [7:0] CODE_LSHIFT = 8'h12;
  localparam logic [7:0] CODE_RSHIFT = 8'h59;
  localparam logic [7:0] CODE_ALT = 8'h11;
  localparam logic [7:0] CODE_CTRL = 8'h14;

  localparam logic [2:0] MOD_SHIFT = 3'b001;
  localparam logic [2:0] MOD_ALT = 3'b010;
  localparam logic [2:0] MOD_CTRL = 3'b100;

  localparam logic [1:0] KIND_ASCII = 2'd0;
  localparam logic [1:0] KIND_FUNCTION = 2'd1;
  localparam logic [1:0] KIND_POSITION = 2'd2;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    SEQ_EMPTY     = 4'b0001,
    SEQ_BREAK     = 4'b0010,
    SEQ_EXT       = 4'b0100,
    SEQ_EXT_BREAK = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] scan_byte;
  } req_t;

  typedef struct packed {
    logic [1:0] key_kind;
    logic [6:0] key_value;
    logic       released;
    logic       shift_held;
    logic       alt_held;
    logic       ctrl_held;
    logic       repeated;
  } rsp_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
    logic [6:0] value;
    logic       released;
    seq_state_t state_next;
    logic [2:0] mods_next;
  } dec_t;

  localparam logic [6:0] ASCII_OF [0:127] = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h51, 7'h31, 7'h00,
    7'h00, 7'h00, 7'h5A, 7'h53, 7'h41, 7'h57, 7'h32, 7'h00,
    7'h00, 7'h43, 7'h58, 7'h44, 7'h45, 7'h34, 7'h33, 7'h00,
    7'h00, 7'h20, 7'h56, 7'h46, 7'h54, 7'h52, 7'h35, 7'h00,
    7'h00, 7'h4E, 7'h42, 7'h48, 7'h47, 7'h59, 7'h36, 7'h00,
    7'h00, 7'h00, 7'h4D, 7'h4A, 7'h55, 7'h37, 7'h38, 7'h00,
    7'h00, 7'h2C, 7'h4B, 7'h49, 7'h4F, 7'h30, 7'h39, 7'h00,
    7'h2E, 7'h00, 7'h00, 7'h4C, 7'h00, 7'h50, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h0D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h08, 7'h00,
    7'h00, 7'h31, 7'h00, 7'h34, 7'h37, 7'h00, 7'h00, 7'h00,
    7'h30, 7'h2E, 7'h32, 7'h35, 7'h36, 7'h38, 7'h1B, 7'h00,
    7'h00, 7'h00, 7'h33, 7'h00, 7'h39, 7'h00, 7'h00, 7'h00
  };

  function automatic logic [3:0] function_number(input logic [7:0] code);
    logic [3:0] num;
    unique case (code)
      8'h05:   num = 4'd1;
      8'h06:   num = 4'd2;
      8'h04:   num = 4'd3;
      8'h0C:   num = 4'd4;
      8'h03:   num = 4'd5;
      8'h0B:   num = 4'd6;
      8'h83:   num = 4'd7;
      8'h0A:   num = 4'd8;
      8'h01:   num = 4'd9;
      8'h09:   num = 4'd10;
      8'h78:   num = 4'd11;
      8'h07:   num = 4'd12;
      default: num = 4'd0;
    endcase
    return num;
  endfunction

  function automatic logic [3:0] position_number(input logic [7:0] code);
    logic [3:0] num;
    unique case (code)
      8'h6C:   num = 4'd1;
      8'h7D:   num = 4'd2;
      8'h7A:   num = 4'd3;
      8'h69:   num = 4'd4;
      8'h75:   num = 4'd5;
      8'h72:   num = 4'd6;
      8'h6B:   num = 4'd7;
      8'h74:   num = 4'd8;
      default: num = 4'd0;
    endcase
    return num;
  endfunction

endpackage

/* design/ps2_scan_code_key_decoder_core.sv */
// Top level of the PS/2 set-2 scan code key decoder with its request and result registers.
// A request is taken into an input register and decoded from there into the result register,
// which offers the key report. One request can be accepted in every cycle; the only thing
// that slows the block is a stalled result, which holds the result register and, once the
// input register is also full, stalls the request side. Shift, alt and ctrl codes and prefix
// bytes give no result.
module ps2_scan_code_key_decoder_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  ps2kd_pkg::req_t                   req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output ps2kd_pkg::rsp_t                   rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ps2kd_pkg::TIMEOUT_W-1:0]   cfg_data
);

  logic                                in_valid;
  ps2kd_pkg::req_t                     in_req;
  logic                                advance;
  logic                                process;
  ps2kd_pkg::op_t                      op;
  ps2kd_pkg::seq_state_t               seq_state;
  ps2kd_pkg::seq_state_t               seq_state_next;
  logic [2:0]                          mods;
  logic [2:0]                          mods_next;
  logic [ps2kd_pkg::TIMEOUT_W-1:0]     timeout_ticks;
  logic [ps2kd_pkg::TIMEOUT_W-1:0]     countdown;
  logic [ps2kd_pkg::TIMEOUT_W-1:0]     countdown_next;
  logic [ps2kd_pkg::KEY_WORD_W-1:0]    last_key;
  logic [ps2kd_pkg::KEY_WORD_W-1:0]    key_word;
  logic                                report;
  ps2kd_pkg::dec_t                     dec;

  assign advance = !rsp_valid || !rsp_stall;
  assign req_stall = in_valid && !advance;
  assign process = in_valid && advance;
  assign op = ps2kd_pkg::op_t'(in_req.operation);
  assign cfg_ready = 1'b1;

  ps2kd_decode u_decode (
    .state     (seq_state),
    .scan_byte (in_req.scan_byte),
    .mods      (mods),
    .dec       (dec)
  );

  assign report = process && op == ps2kd_pkg::OP_BYTE && dec.hit;
  assign key_word = {mods, dec.released, dec.kind, dec.value};

  always_comb begin
    seq_state_next = seq_state;
    mods_next = mods;
    countdown_next = countdown;
    if (process) begin
      case (op)
        ps2kd_pkg::OP_BYTE: begin
          seq_state_next = dec.state_next;
          mods_next = dec.mods_next;
          countdown_next = timeout_ticks;
        end
        ps2kd_pkg::OP_TICK: begin
          if (countdown <= ps2kd_pkg::TIMEOUT_W'(1)) begin
            countdown_next = '0;
            seq_state_next = ps2kd_pkg::SEQ_EMPTY;
          end else begin
            countdown_next = countdown - ps2kd_pkg::TIMEOUT_W'(1);
          end
        end
        ps2kd_pkg::OP_FLUSH: begin
          countdown_next = '0;
          seq_state_next = ps2kd_pkg::SEQ_EMPTY;
        end
        default: begin
          seq_state_next = seq_state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rsp_valid <= 1'b0;
      seq_state <= ps2kd_pkg::SEQ_EMPTY;
      mods <= '0;
      countdown <= '0;
      last_key <= '0;
      timeout_ticks <= ps2kd_pkg::TIMEOUT_RESET;
    end else begin
      if (req_valid && !req_stall) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (process) begin
        rsp_valid <= report;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      seq_state <= seq_state_next;
      mods <= mods_next;
      countdown <= countdown_next;
      if (report) begin
        last_key <= key_word;
      end
      if (cfg_valid && cfg_ready) begin
        timeout_ticks <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_req <= req;
    end
    if (report) begin
      rsp.key_kind <= dec.kind;
      rsp.key_value <= dec.value;
      rsp.released <= dec.released;
      rsp.shift_held <= mods[0];
      rsp.alt_held <= mods[1];
      rsp.ctrl_held <= mods[2];
      rsp.repeated <= key_word == last_key;
    end
  end

  a_flush_clears : assert property (@(posedge clk) disable iff (rst)
    process && op == ps2kd_pkg::OP_FLUSH |=> seq_state == ps2kd_pkg::SEQ_EMPTY && countdown == '0)
    else $error("Flush did not empty the sequence state.");

  a_report_recorded : assert property (@(posedge clk) disable iff (rst)
    report |=> rsp_valid && last_key == {rsp.ctrl_held, rsp.alt_held, rsp.shift_held,
                                         rsp.released, rsp.key_kind, rsp.key_value})
    else $error("Reported key does not match the stored last key.");

  a_mods_only_on_byte : assert property (@(posedge clk) disable iff (rst)
    !(process && op == ps2kd_pkg::OP_BYTE) |=> $stable(mods))
    else $error("Modifier bits changed without a scan byte.");

  a_timeout_expires : assert property (@(posedge clk) disable iff (rst)
    process && op == ps2kd_pkg::OP_TICK && countdown <= ps2kd_pkg::TIMEOUT_W'(1)
    |=> seq_state == ps2kd_pkg::SEQ_EMPTY && countdown == '0)
    else $error("Expired timeout did not discard the partial sequence.");

endmodule

/* design/ps2kd_decode.sv */
// Combinational decode of one scan byte against the pending prefix state and modifiers.
module ps2kd_decode (
  input  ps2kd_pkg::seq_state_t state,
  input  logic [7:0]            scan_byte,
  input  logic [2:0]            mods,
  output ps2kd_pkg::dec_t       dec
);

  logic       extended;
  logic       brk;
  logic [2:0] mask;
  logic [6:0] ascii;
  logic [3:0] fn_num;
  logic [3:0] pos_num;

  assign ascii = ps2kd_pkg::ASCII_OF[scan_byte[6:0]];
  assign fn_num = ps2kd_pkg::function_number(scan_byte);
  assign pos_num = ps2kd_pkg::position_number(scan_byte);

  always_comb begin
    extended = 1'b0;
    brk = 1'b0;
    unique case (state)
      ps2kd_pkg::SEQ_EMPTY: begin
        extended = 1'b0;
        brk = 1'b0;
      end
      ps2kd_pkg::SEQ_BREAK: begin
        extended = 1'b0;
        brk = 1'b1;
      end
      ps2kd_pkg::SEQ_EXT: begin
        extended = 1'b1;
        brk = 1'b0;
      end
      ps2kd_pkg::SEQ_EXT_BREAK: begin
        extended = 1'b1;
        brk = 1'b1;
      end
      default: begin
        extended = 1'b0;
        brk = 1'b0;
      end
    endcase
  end

  always_comb begin
    mask = 3'b000;
    if (scan_byte == ps2kd_pkg::CODE_ALT) begin
      mask = ps2kd_pkg::MOD_ALT;
    end else if (scan_byte == ps2kd_pkg::CODE_CTRL) begin
      mask = ps2kd_pkg::MOD_CTRL;
    end else if (!extended && (scan_byte == ps2kd_pkg::CODE_LSHIFT ||
                               scan_byte == ps2kd_pkg::CODE_RSHIFT)) begin
      mask = ps2kd_pkg::MOD_SHIFT;
    end
  end

  always_comb begin
    dec = '0;
    dec.released = brk;
    dec.state_next = ps2kd_pkg::SEQ_EMPTY;
    dec.mods_next = mods;
    if (mask != 3'b000) begin
      dec.mods_next = brk ? (mods & ~mask) : (mods | mask);
    end else if (!extended) begin
      if (!scan_byte[7] && ascii != 7'd0) begin
        dec.hit = 1'b1;
        dec.kind = ps2kd_pkg::KIND_ASCII;
        dec.value = ascii;
      end else if (fn_num != 4'd0) begin
        dec.hit = 1'b1;
        dec.kind = ps2kd_pkg::KIND_FUNCTION;
        dec.value = {3'd0, fn_num};
      end else if (scan_byte == ps2kd_pkg::CODE_EXT) begin
        dec.state_next = ps2kd_pkg::SEQ_EXT;
      end else if (scan_byte == ps2kd_pkg::CODE_BREAK) begin
        dec.state_next = ps2kd_pkg::SEQ_BREAK;
      end
    end else begin
      if (pos_num != 4'd0) begin
        dec.hit = 1'b1;
        dec.kind = ps2kd_pkg::KIND_POSITION;
        dec.value = {3'd0, pos_num};
      end else if (scan_byte == ps2kd_pkg::CODE_BREAK) begin
        dec.state_next = ps2kd_pkg::SEQ_EXT_BREAK;
      end
    end
  end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the PS/2 scan code key decoder core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int SEQ_DEPTH = 8;
  localparam logic [7:0] CODE_PAUSE = 8'hE1;
  localparam logic [7:0] CODE_KEY_A = 8'h1C;

  localparam logic [6:0] KEY_ASCII [128] = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h51, 7'h31, 7'h00,
    7'h00, 7'h00, 7'h5A, 7'h53, 7'h41, 7'h57, 7'h32, 7'h00,
    7'h00, 7'h43, 7'h58, 7'h44, 7'h45, 7'h34, 7'h33, 7'h00,
    7'h00, 7'h20, 7'h56, 7'h46, 7'h54, 7'h52, 7'h35, 7'h00,
    7'h00, 7'h4E, 7'h42, 7'h48, 7'h47, 7'h59, 7'h36, 7'h00,
    7'h00, 7'h00, 7'h4D, 7'h4A, 7'h55, 7'h37, 7'h38, 7'h00,
    7'h00, 7'h2C, 7'h4B, 7'h49, 7'h4F, 7'h30, 7'h39, 7'h00,
    7'h2E, 7'h00, 7'h00, 7'h4C, 7'h00, 7'h50, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h0D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h08, 7'h00,
    7'h00, 7'h31, 7'h00, 7'h34, 7'h37, 7'h00, 7'h00, 7'h00,
    7'h30, 7'h2E, 7'h32, 7'h35, 7'h36, 7'h38, 7'h1B, 7'h00,
    7'h00, 7'h00, 7'h33, 7'h00, 7'h39, 7'h00, 7'h00, 7'h00
  };
  localparam logic [7:0] FN_CODES [12] = '{
    8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83, 8'h0A, 8'h01, 8'h09, 8'h78, 8'h07
  };
  localparam logic [7:0] POS_CODES [8] = '{
    8'h6C, 8'h7D, 8'h7A, 8'h69, 8'h75, 8'h72, 8'h6B, 8'h74
  };
  localparam logic [7:0] MOD_CODES [4] = '{
    ps2kd_pkg::CODE_LSHIFT, ps2kd_pkg::CODE_RSHIFT, ps2kd_pkg::CODE_ALT, ps2kd_pkg::CODE_CTRL
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  ps2kd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ps2kd_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  logic [7:0] pend_bytes [SEQ_DEPTH] = '{default: 8'h00};
  int pend_count = 0;
  logic [2:0] held_mods = '0;
  logic [ps2kd_pkg::KEY_WORD_W-1:0] last_key_word = '0;
  logic [15:0] tick_countdown = '0;
  logic [15:0] byte_timeout = 16'd100;

  ps2kd_pkg::rsp_t expected_keys [$];
  int errors = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int stall_left = 0;
  int stall_mode = 0;

  logic [7:0] last_code = 8'h00;
  bit last_ext = 1'b0;
  bit last_rel = 1'b0;
  bit have_last = 1'b0;

  ps2_scan_code_key_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [6:0] code_rank(input bit pos_table, input logic [7:0] code);
    logic [6:0] rank;
    int i;
    rank = '0;
    if (pos_table) begin
      for (i = 0; i < 8; i++) if (POS_CODES[i] == code) rank = 7'(i + 1);
    end else begin
      for (i = 0; i < 12; i++) if (FN_CODES[i] == code) rank = 7'(i + 1);
    end
    return rank;
  endfunction

  function automatic bit decode_scan_byte(input logic [7:0] b, output ps2kd_pkg::rsp_t key);
    bit brk;
    int len;
    logic [7:0] c0, c1;
    logic [2:0] m;
    logic [1:0] kind;
    logic [6:0] val;
    logic [ps2kd_pkg::KEY_WORD_W-1:0] code;
    brk = 1'b0;
    key = '0;
    kind = ps2kd_pkg::KIND_ASCII;
    val = '0;
    if (pend_count >= SEQ_DEPTH) pend_count = 0;
    pend_bytes[pend_count] = b;
    pend_count++;
    tick_countdown = byte_timeout;
    len = pend_count;
    if (len == 3 && pend_bytes[1] == ps2kd_pkg::CODE_BREAK) begin
      pend_bytes[1] = pend_bytes[2];
      len = 2;
      brk = 1'b1;
    end
    if (len == 2 && pend_bytes[0] == ps2kd_pkg::CODE_BREAK) begin
      pend_bytes[0] = pend_bytes[1];
      len = 1;
      brk = 1'b1;
    end
    pend_count = len;
    c0 = pend_bytes[0];
    c1 = (len == 2) ? pend_bytes[1] : 8'h00;
    if (c0 == ps2kd_pkg::CODE_LSHIFT || c0 == ps2kd_pkg::CODE_RSHIFT) m = ps2kd_pkg::MOD_SHIFT;
    else if (c0 == ps2kd_pkg::CODE_ALT || c1 == ps2kd_pkg::CODE_ALT) m = ps2kd_pkg::MOD_ALT;
    else if (c0 == ps2kd_pkg::CODE_CTRL || c1 == ps2kd_pkg::CODE_CTRL) m = ps2kd_pkg::MOD_CTRL;
    else m = '0;
    if (m != '0) begin
      held_mods = brk ? (held_mods & ~m) : (held_mods | m);
      pend_count = 0;
      return 1'b0;
    end
    if (!c0[7] && KEY_ASCII[c0[6:0]] != '0) begin
      kind = ps2kd_pkg::KIND_ASCII;
      val = KEY_ASCII[c0[6:0]];
    end else if (code_rank(1'b0, c0) != '0) begin
      kind = ps2kd_pkg::KIND_FUNCTION;
      val = code_rank(1'b0, c0);
    end else if (c0 == ps2kd_pkg::CODE_EXT && len == 2 && code_rank(1'b1, c1) != '0) begin
      kind = ps2kd_pkg::KIND_POSITION;
      val = code_rank(1'b1, c1);
    end else begin
      if ((c0 == ps2kd_pkg::CODE_EXT && len == 2 && c1 != ps2kd_pkg::CODE_BREAK) ||
          (c0 != ps2kd_pkg::CODE_EXT && c0 != ps2kd_pkg::CODE_BREAK))
        pend_count = 0;
      return 1'b0;
    end
    pend_count = 0;
    code = {held_mods, brk, kind, val};
    key.key_kind = kind;
    key.key_value = val;
    key.released = brk;
    key.shift_held = held_mods[0];
    key.alt_held = held_mods[1];
    key.ctrl_held = held_mods[2];
    key.repeated = (code == last_key_word);
    if (code != last_key_word) last_key_word = code;
    return 1'b1;
  endfunction

  task automatic send_req(input ps2kd_pkg::op_t op, input logic [7:0] b);
    int gap;
    ps2kd_pkg::rsp_t key;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= '{operation: op, scan_byte: b};
    do @(posedge clk); while (req_stall);
    case (op)
      ps2kd_pkg::OP_BYTE: begin
        bytes_sent++;
        if (decode_scan_byte(b, key)) expected_keys.push_back(key);
      end
      ps2kd_pkg::OP_TICK: begin
        if (tick_countdown <= 16'd1) begin
          tick_countdown = '0;
          pend_count = 0;
        end else begin
          tick_countdown--;
        end
      end
      ps2kd_pkg::OP_FLUSH: begin
        pend_count = 0;
        tick_countdown = '0;
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    burst_left = 0;
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_byte_timeout(input logic [15:0] ticks);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    byte_timeout = ticks;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_key(input string what, input ps2kd_pkg::rsp_t want,
                          input ps2kd_pkg::rsp_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%s: expected kind %0d value %h rel %b mods %b%b%b rep %b",
               what, want.key_kind, want.key_value, want.released, want.ctrl_held,
               want.alt_held, want.shift_held, want.repeated);
      $display("  got kind %0d value %h rel %b mods %b%b%b rep %b",
               got.key_kind, got.key_value, got.released, got.ctrl_held,
               got.alt_held, got.shift_held, got.repeated);
    end
  endtask

  always @(posedge clk) begin
    ps2kd_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_keys.size() == 0) begin
        flag_key("key reported with none pending", '0, rsp);
      end else begin
        want = expected_keys.pop_front();
        if (rsp.key_kind !== want.key_kind || rsp.key_value !== want.key_value ||
            rsp.released !== want.released || rsp.shift_held !== want.shift_held ||
            rsp.alt_held !== want.alt_held || rsp.ctrl_held !== want.ctrl_held ||
            rsp.repeated !== want.repeated)
          flag_key("key mismatch", want, rsp);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 1) == 1);
      default: rsp_stall <= ((stall_left % 8) < 5);
    endcase
  end

  task automatic test_ascii_keys();
    send_req(ps2kd_pkg::OP_BYTE, 8'h00);
    send_req(ps2kd_pkg::OP_BYTE, 8'hFF);
    send_req(ps2kd_pkg::OP_BYTE, CODE_KEY_A);
    send_req(ps2kd_pkg::OP_BYTE, CODE_KEY_A);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_BREAK);
    send_req(ps2kd_pkg::OP_BYTE, CODE_KEY_A);
  endtask

  task automatic test_modifier_keys();
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_LSHIFT);
    send_req(ps2kd_pkg::OP_BYTE, CODE_KEY_A);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_BREAK);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_LSHIFT);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_EXT);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_CTRL);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_EXT);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_BREAK);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_CTRL);
  endtask

  task automatic test_function_and_position_keys();
    send_req(ps2kd_pkg::OP_BYTE, 8'h83);
    send_req(ps2kd_pkg::OP_BYTE, 8'h07);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_EXT);
    send_req(ps2kd_pkg::OP_BYTE, 8'h74);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_EXT);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_BREAK);
    send_req(ps2kd_pkg::OP_BYTE, 8'h6C);
  endtask

  task automatic test_prefix_and_operations();
    send_req(ps2kd_pkg::OP_BYTE, CODE_PAUSE);
    send_req(ps2kd_pkg::OP_NONE, 8'hFF);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_EXT);
    send_req(ps2kd_pkg::OP_FLUSH, 8'h00);
    send_req(ps2kd_pkg::OP_BYTE, 8'h6C);
  endtask

  task automatic test_byte_timeout();
    set_byte_timeout(16'd1);
    send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_EXT);
    send_req(ps2kd_pkg::OP_TICK, 8'h55);
    send_req(ps2kd_pkg::OP_TICK, 8'hAA);
    send_req(ps2kd_pkg::OP_BYTE, 8'h74);
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) send_req(ps2kd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_key();
    int pick;
    logic [7:0] code;
    bit ext;
    bit rel;
    pick = $urandom_range(0, 99);
    ext = 1'b0;
    rel = ($urandom_range(0, 2) == 0);
    if (pick < 12 && have_last) begin
      code = last_code;
      ext = last_ext;
      rel = last_rel;
    end else if (pick < 45) begin
      code = 8'($urandom_range(0, 127));
    end else if (pick < 55) begin
      code = FN_CODES[$urandom_range(0, 11)];
    end else if (pick < 70) begin
      code = POS_CODES[$urandom_range(0, 7)];
      ext = 1'b1;
    end else if (pick < 85) begin
      code = MOD_CODES[$urandom_range(0, 3)];
      ext = (code == ps2kd_pkg::CODE_ALT || code == ps2kd_pkg::CODE_CTRL) &&
            ($urandom_range(0, 1) == 1);
    end else begin
      case ($urandom_range(0, 5))
        0: send_req(ps2kd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        1: begin
          send_req(ps2kd_pkg::OP_BYTE, CODE_PAUSE);
          send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_CTRL);
          send_req(ps2kd_pkg::OP_BYTE, 8'h77);
        end
        2: begin
          send_req(ps2kd_pkg::OP_BYTE, ($urandom_range(0, 1) == 1) ?
                   ps2kd_pkg::CODE_EXT : ps2kd_pkg::CODE_BREAK);
          if ($urandom_range(0, 1) == 1) send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_BREAK);
          send_req(ps2kd_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
        end
        3: begin
          send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_EXT);
          repeat ($urandom_range(1, 8))
            send_req(ps2kd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
        end
        4: send_req(ps2kd_pkg::OP_NONE, 8'($urandom_range(0, 255)));
        default: begin
          send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_EXT);
          send_req(ps2kd_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        end
      endcase
      return;
    end
    last_code = code;
    last_ext = ext;
    last_rel = rel;
    have_last = 1'b1;
    if (ext) begin
      send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_EXT);
      maybe_ticks();
    end
    if (rel) begin
      send_req(ps2kd_pkg::OP_BYTE, ps2kd_pkg::CODE_BREAK);
      maybe_ticks();
    end
    send_req(ps2kd_pkg::OP_BYTE, code);
    maybe_ticks();
  endtask

  task automatic test_random_typing();
    logic [15:0] settings [6];
    int target;
    int k;
    settings = '{16'd5, 16'd0, 16'd65535, 16'd2, 16'd100, 16'd0};
    settings[5] = 16'($urandom_range(1, 30));
    for (k = 0; k < 6; k++) begin
      set_byte_timeout(settings[k]);
      target = bytes_sent + 80;
      while (bytes_sent < target) send_random_key();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_ascii_keys();
    test_modifier_keys();
    test_function_and_position_keys();
    test_prefix_and_operations();
    test_byte_timeout();
    test_random_typing();
    wait_drained();
    if (errors == 0 && expected_keys.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ps2kd_pkg.sv
design/ps2kd_decode.sv
design/ps2_scan_code_key_decoder_core.sv
verif/testbench.sv
